// ===== rtl/keyed_lifo_stack_defines.svh =====
// ============================================================================
// keyed_lifo_stack_defines.svh
// Assertion macros shared by the keyed LIFO stack RTL.
// ============================================================================
`ifndef KEYED_LIFO_STACK_DEFINES_SVH
`define KEYED_LIFO_STACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define KLS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define KLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/klstk_pkg.sv =====
// ============================================================================
// klstk_pkg
// Constants, codes, transaction types and helpers for the keyed LIFO stack.
// ============================================================================
`default_nettype none

package klstk_pkg;

    // Stack size and derived widths
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Fixed field widths
    localparam int KIND_W    = 3;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_W   = 5;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam cnt_t FULL_COUNT = cnt_t'(STACK_DEPTH);

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [KEY_W-1:0]  key;
        logic [PAYLOAD_W-1:0]     payload;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [KEY_W-1:0]  out_key;
        logic [PAYLOAD_W-1:0]     out_payload;
        logic [DEPTH_W-1:0]       depth;
    } out_item_t;

    // One stored entry
    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic [PAYLOAD_W-1:0]     payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Fill count shown in the 5-bit depth field (zero-extended or masked)
    function automatic logic [DEPTH_W-1:0] depth_field(input cnt_t count);
        logic [CNT_W+DEPTH_W-1:0] wide;
        wide = {{DEPTH_W{1'b0}}, count};
        return wide[DEPTH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/klstk_ram.sv =====
// ============================================================================
// klstk_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module klstk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/keyed_lifo_stack.sv =====
// ============================================================================
// keyed_lifo_stack
// Bounded LIFO of key/payload entries with push, pop, peek, find and remove.
// ============================================================================
//
//  Channel | Ports                      | Transaction
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | kind, key, payload
//  result  | m_valid, m_ready, m_data   | status, out_key, out_payload, depth
//
//  Steps: push, unknown kind or empty stack go straight to the result; pop and
//  peek read the top entry; find compares N entries from the top; remove also
//  moves M entries down, one entry per cycle through the single read port.
//  Reset (aresetn low, synchronous) empties the stack; entry memory not cleared.
//  One transaction is in work at a time; the next input is taken while a
//  finished result waits in the output register for m_ready.
//
`default_nettype none

module keyed_lifo_stack (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire klstk_pkg::in_item_t   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output klstk_pkg::out_item_t       m_data
);

    `include "keyed_lifo_stack_defines.svh"

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_TOP   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                               state_reg, state_next;
    klstk_pkg::cnt_t                      fill_reg, fill_next;
    logic [klstk_pkg::KIND_W-1:0]         op_kind_reg, op_kind_next;
    logic signed [klstk_pkg::KEY_W-1:0]   op_key_reg, op_key_next;
    klstk_pkg::addr_t                     cmp_addr_reg, cmp_addr_next;
    klstk_pkg::addr_t                     sh_addr_reg, sh_addr_next;
    logic [klstk_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic signed [klstk_pkg::KEY_W-1:0]   res_key_reg, res_key_next;
    logic [klstk_pkg::PAYLOAD_W-1:0]      res_payload_reg, res_payload_next;
    logic                                 m_valid_reg, m_valid_next;
    klstk_pkg::out_item_t                 m_data_reg, m_data_next;

    // Entry memory ports
    logic                                 wr_en;
    klstk_pkg::addr_t                     wr_addr;
    klstk_pkg::entry_t                    wr_entry;
    klstk_pkg::addr_t                     rd_addr;
    klstk_pkg::entry_t                    rd_entry;
    logic [klstk_pkg::ENTRY_W-1:0]        rd_word;

    klstk_pkg::addr_t                     top_addr;
    logic                                 key_hit;

    klstk_ram #(
        .WIDTH (klstk_pkg::ENTRY_W),
        .DEPTH (klstk_pkg::STACK_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = klstk_pkg::entry_t'(rd_word);
    assign top_addr = klstk_pkg::addr_t'(fill_reg - 1'b1);
    assign key_hit  = (rd_entry.key == op_key_reg);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Sequencer: accept, read/compare/shift through the memory, then emit
    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        op_kind_next     = op_kind_reg;
        op_key_next      = op_key_reg;
        cmp_addr_next    = cmp_addr_reg;
        sh_addr_next     = sh_addr_reg;
        res_status_next  = res_status_reg;
        res_key_next     = res_key_reg;
        res_payload_next = res_payload_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        wr_en            = 1'b0;
        wr_addr          = klstk_pkg::addr_t'(fill_reg);
        wr_entry.key     = s_data.key;
        wr_entry.payload = s_data.payload;
        rd_addr          = top_addr;

        // Result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_kind_next     = s_data.kind;
                    op_key_next      = s_data.key;
                    res_status_next  = klstk_pkg::STAT_OK;
                    res_key_next     = '0;
                    res_payload_next = '0;
                    state_next       = ST_EMIT;
                    case (s_data.kind)
                        klstk_pkg::KIND_PUSH: begin
                            if (fill_reg == klstk_pkg::FULL_COUNT) begin
                                res_status_next = klstk_pkg::STAT_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        klstk_pkg::KIND_POP,
                        klstk_pkg::KIND_PEEK: begin
                            if (fill_reg == '0) begin
                                res_status_next = klstk_pkg::STAT_EMPTY;
                            end else begin
                                state_next = ST_TOP;
                            end
                        end
                        klstk_pkg::KIND_FIND,
                        klstk_pkg::KIND_REMOVE: begin
                            if (fill_reg == '0) begin
                                res_status_next = klstk_pkg::STAT_EMPTY;
                            end else begin
                                cmp_addr_next = top_addr;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Top entry read data is ready
            ST_TOP: begin
                res_key_next     = rd_entry.key;
                res_payload_next = rd_entry.payload;
                if (op_kind_reg == klstk_pkg::KIND_POP) begin
                    fill_next = fill_reg - 1'b1;
                end
                state_next = ST_EMIT;
            end

            // One entry compared per cycle, top downward
            ST_SCAN: begin
                rd_addr = cmp_addr_reg - 1'b1;
                if (key_hit) begin
                    res_key_next     = rd_entry.key;
                    res_payload_next = rd_entry.payload;
                    state_next       = ST_EMIT;
                    if (op_kind_reg == klstk_pkg::KIND_REMOVE) begin
                        rd_addr = cmp_addr_reg + 1'b1;
                        if (klstk_pkg::cnt_t'(cmp_addr_reg) == fill_reg - 1'b1) begin
                            fill_next = fill_reg - 1'b1;
                        end else begin
                            sh_addr_next = cmp_addr_reg + 1'b1;
                            state_next   = ST_SHIFT;
                        end
                    end
                end else if (cmp_addr_reg == '0) begin
                    res_status_next = klstk_pkg::STAT_NOTFOUND;
                    state_next      = ST_EMIT;
                end else begin
                    cmp_addr_next = cmp_addr_reg - 1'b1;
                end
            end

            // Close the gap: entry at sh_addr moves down one place
            ST_SHIFT: begin
                wr_en    = 1'b1;
                wr_addr  = sh_addr_reg - 1'b1;
                wr_entry = rd_entry;
                rd_addr  = sh_addr_reg + 1'b1;
                if (klstk_pkg::cnt_t'(sh_addr_reg) == fill_reg - 1'b1) begin
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    sh_addr_next = sh_addr_reg + 1'b1;
                end
            end

            // Load the output register once it is free
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.out_key     = res_key_reg;
                    m_data_next.out_payload = res_payload_reg;
                    m_data_next.depth       = klstk_pkg::depth_field(fill_reg);
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_kind_reg     <= op_kind_next;
        op_key_reg      <= op_key_next;
        cmp_addr_reg    <= cmp_addr_next;
        sh_addr_reg     <= sh_addr_next;
        res_status_reg  <= res_status_next;
        res_key_reg     <= res_key_next;
        res_payload_reg <= res_payload_next;
        m_data_reg      <= m_data_next;
    end

    // Checks
    `KLS_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1,
        fill_reg <= klstk_pkg::FULL_COUNT, "fill count above stack depth")
    `KLS_ASSERT_NEXT(a_push_grows, aclk, aresetn,
        s_valid && s_ready && s_data.kind == klstk_pkg::KIND_PUSH
            && fill_reg != klstk_pkg::FULL_COUNT,
        fill_reg == $past(fill_reg) + 1'b1, "accepted push did not add an entry")
    `KLS_ASSERT_SAME(a_full_depth, aclk, aresetn,
        m_valid && m_data.status == klstk_pkg::STAT_FULL,
        m_data.depth == klstk_pkg::depth_field(klstk_pkg::FULL_COUNT),
        "full reported below full depth")
    `KLS_ASSERT_SAME(a_fail_zero, aclk, aresetn,
        m_valid && m_data.status != klstk_pkg::STAT_OK,
        m_data.out_key == '0 && m_data.out_payload == '0,
        "failed transaction returned entry data")

endmodule

`default_nettype wire
